// ===== rtl/tftp_read_receiver_sequencer_macros.svh =====
// Assertion macros used by the checker file of the read receiver.
// Needs clk and rst_n visible at the point of use.
`ifndef TFTP_READ_RECEIVER_SEQUENCER_MACROS_SVH
`define TFTP_READ_RECEIVER_SEQUENCER_MACROS_SVH

// Checked outside reset only.
`define TRS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TRS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/trs_pkg.sv =====
// Shared types and constants of the read receiver sequencer.
// No dependencies.
package trs_pkg;

    localparam int MAX_PAYLOAD  = 512;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [9:0]  HEADER_BYTES  = 10'd4;
    localparam logic [16:0] MAX_PAYLOAD_W = 17'(MAX_PAYLOAD);
    localparam logic [15:0] OP_DATA       = 16'd3;
    localparam logic [15:0] OP_ERROR      = 16'd5;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_PACKET  = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_UNUSED  = 2'd3
    } trs_action_t;

    typedef enum logic [2:0] {
        ST_RUNNING    = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_TIMEOUT    = 3'd2,
        ST_SHORT      = 3'd3,
        ST_SERVER_ERR = 3'd4,
        ST_IDLE       = 3'd5
    } trs_status_t;

    typedef enum logic [2:0] {
        KIND_NOP     = 3'd0,
        KIND_START   = 3'd1,
        KIND_TIMEOUT = 3'd2,
        KIND_SHORT   = 3'd3,
        KIND_ERROR   = 3'd4,
        KIND_DATA    = 3'd5
    } trs_kind_t;

    // Classified event passed from front to back
    typedef struct packed {
        trs_kind_t   kind;
        logic [15:0] block;
        logic [9:0]  payload_len;  // already capped at MAX_PAYLOAD
        logic        full;         // payload reached MAX_PAYLOAD
    } trs_item_t;

endpackage

// ===== rtl/trs_front.sv =====
// Front end: accepts input transactions and classifies each event.
// Depends on trs_pkg.
module trs_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,  // packet_length[9:0], packet_opcode[25:10],
                                        // packet_block[41:26], zero fill
    input  logic [1:0]        s_tuser,  // action[1:0]
    input  logic              q_full,
    output logic              push,
    output trs_pkg::trs_item_t push_item
);
    import trs_pkg::*;

    trs_action_t  act;
    logic [9:0]   plen;
    logic [15:0]  opcode;
    logic [9:0]   raw_payload;
    logic [16:0]  payload_ext;
    logic         full;

    assign act    = trs_action_t'(s_tuser);
    assign plen   = s_tdata[9:0];
    assign opcode = s_tdata[25:10];

    assign raw_payload = plen - HEADER_BYTES;
    assign payload_ext = {7'd0, raw_payload};
    assign full        = (payload_ext >= MAX_PAYLOAD_W);

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_item.block       = s_tdata[41:26];
        push_item.full        = full;
        push_item.payload_len = full ? MAX_PAYLOAD_W[9:0] : raw_payload;
        unique case (act)
            ACT_START:   push_item.kind = KIND_START;
            ACT_TIMEOUT: push_item.kind = KIND_TIMEOUT;
            ACT_PACKET:
            begin
                priority if (plen < HEADER_BYTES) push_item.kind = KIND_SHORT;
                else if (opcode == OP_ERROR)      push_item.kind = KIND_ERROR;
                else if (opcode == OP_DATA)       push_item.kind = KIND_DATA;
                else                              push_item.kind = KIND_NOP;
            end
            default:     push_item.kind = KIND_NOP;
        endcase
    end

endmodule

// ===== rtl/trs_queue.sv =====
// Short FIFO of classified events between front and back.
// Depends on trs_pkg.
module trs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  trs_pkg::trs_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output trs_pkg::trs_item_t pop_item
);
    import trs_pkg::*;

    trs_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = push   ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/trs_back.sv =====
// Back end: block sequencing state and the registered result stage.
// Depends on trs_pkg.
module trs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  trs_pkg::trs_item_t q_item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata   // write_payload[0], payload_length[10:1],
                                         // ack_req[11], ack_num[27:12],
                                         // status[30:28], zero fill
);
    import trs_pkg::*;

    logic        active_reg, active_next;
    logic [15:0] exp_block_reg, exp_block_next;
    logic        out_valid_reg, out_valid_next;
    logic        wr_reg, wr_next;
    logic [9:0]  wlen_reg, wlen_next;
    logic        ack_reg, ack_next;
    logic [15:0] ackb_reg, ackb_next;
    trs_status_t status_reg, status_next;

    assign pop = q_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        active_next    = active_reg;
        exp_block_next = exp_block_reg;
        wr_next        = wr_reg;
        wlen_next      = wlen_reg;
        ack_next       = ack_reg;
        ackb_next      = ackb_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (pop)
        begin
            out_valid_next = 1'b1;
            wr_next        = 1'b0;
            wlen_next      = '0;
            ack_next       = 1'b0;
            ackb_next      = '0;
            status_next    = active_reg ? ST_RUNNING : ST_IDLE;
            unique case (q_item.kind)
                KIND_START:
                begin
                    exp_block_next = 16'd1;
                    active_next    = 1'b1;
                    status_next    = ST_RUNNING;
                end
                KIND_TIMEOUT:
                    if (active_reg)
                    begin
                        active_next = 1'b0;
                        status_next = ST_TIMEOUT;
                    end
                KIND_SHORT:
                    if (active_reg)
                    begin
                        active_next = 1'b0;
                        status_next = ST_SHORT;
                    end
                KIND_ERROR:
                    if (active_reg)
                    begin
                        active_next = 1'b0;
                        status_next = ST_SERVER_ERR;
                    end
                KIND_DATA:
                    if (active_reg)
                    begin
                        if (q_item.block == exp_block_reg)
                        begin
                            wr_next        = 1'b1;
                            wlen_next      = q_item.payload_len;
                            ack_next       = 1'b1;
                            ackb_next      = q_item.block;
                            exp_block_next = exp_block_reg + 16'd1;
                            // short final block closes the transfer
                            if (!q_item.full)
                            begin
                                active_next = 1'b0;
                                status_next = ST_COMPLETE;
                            end
                        end
                        else if (q_item.block < exp_block_reg)
                        begin
                            // duplicate: re-ack only
                            ack_next  = 1'b1;
                            ackb_next = q_item.block;
                        end
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            exp_block_reg <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            exp_block_reg <= exp_block_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_reg     <= wr_next;
        wlen_reg   <= wlen_next;
        ack_reg    <= ack_next;
        ackb_reg   <= ackb_next;
        status_reg <= status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, status_reg, ackb_reg, ack_reg, wlen_reg, wr_reg};

endmodule

// ===== rtl/tftp_read_receiver_sequencer.sv =====
// Top level of the read-transfer receive sequencer.
// Depends on trs_pkg, trs_front, trs_queue, trs_back.
//
//  channel   dir  tdata                                      tuser
//  s_axis    in   length, opcode, block (48 bits)            action (2 bits)
//  m_axis    out  write, payload len, ack, ack block, status  -
//
// One transaction per cycle sustained while m_tready holds; a result passes the
// 4-entry event queue (classified on entry), then the state/result register.
// The block-number compare against the expected-block register sets the path.
// Reset: asynchronous, transfer idle, expected block 1, queue empty.
// A stalled output fills the queue; s_tready drops only when it is full.
module tftp_read_receiver_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // packet_length[9:0], packet_opcode[25:10],
                                   // packet_block[41:26], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // write_payload[0], payload_length[10:1],
                                   // ack_req[11], ack_num[27:12],
                                   // status[30:28], zero fill
);
    import trs_pkg::*;

    logic      push;
    trs_item_t push_item;
    logic      q_full;
    logic      pop;
    logic      q_valid;
    trs_item_t q_item;

    trs_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    trs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .pop_item  (q_item)
    );

    trs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/trs_checker.sv =====
// Port-level checks of the read receiver sequencer, bound to the top level.
// Depends on trs_pkg and tftp_read_receiver_sequencer_macros.svh.
`include "tftp_read_receiver_sequencer_macros.svh"

module trs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import trs_pkg::*;

    `TRS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |-> !m_tvalid,
                       "result valid during reset")
    `TRS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
                "stalled result changed")
    `TRS_ASSERT(a_write_acks, m_tvalid && m_tdata[0] |-> m_tdata[11] &&
                (m_tdata[30:28] == ST_RUNNING || m_tdata[30:28] == ST_COMPLETE),
                "stored block not acked while running")
    `TRS_ASSERT(a_idle_quiet, m_tvalid && m_tdata[30:28] == ST_IDLE |->
                !m_tdata[0] && !m_tdata[11] && m_tdata[27:1] == 27'd0,
                "idle result carries an action")

endmodule

bind tftp_read_receiver_sequencer trs_checker u_trs_checker (.*);
